[design/meter_uart_register_access_unit_defines.svh]
// assertion macros shared by the register access unit modules
// depends on nothing; included by the modules that carry assertions
`ifndef METER_UART_REGISTER_ACCESS_UNIT_DEFINES_SVH
`define METER_UART_REGISTER_ACCESS_UNIT_DEFINES_SVH

// same-cycle implication
`define MURA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define MURA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[design/mura_pkg.sv]
// types and constants of the meter uart register access unit
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package mura_pkg;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_BYTE  = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [1:0] CSR_HEAD    = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_LIMIT   = 2'd2;

   localparam logic [7:0] ACK_BYTE   = 8'h54;
   localparam logic [7:0] HEAD_RESET = 8'd106;
   localparam logic [9:0] TIMEOUT_RESET = 10'd1000;
   localparam logic [4:0] LIMIT_RESET   = 5'd20;

   localparam int FRAME_DEPTH = 5;
   localparam int CNT_W = 3;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_WRITE = 3'b010,
      PH_READ  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  address;
      logic [15:0] write_data;
      logic [7:0]  rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [9:0] timeout_ticks;
      logic [4:0] fail_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [23:0] read_value;
      logic        success;
      logic        comm_fault;
      logic [4:0]  fail_count;
   } word_type;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } frame_ctl_type;

endpackage

`default_nettype wire

[design/mura_core.sv]
// input register, protocol state and per-item step logic
// depends on mura_pkg and the shared assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "meter_uart_register_access_unit_defines.svh"

module mura_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mura_pkg::item_type req_item,
   input  wire mura_pkg::cfg_type  cfg,
   input  wire logic              frame_free,
   output mura_pkg::frame_ctl_type frame_ctl,
   output mura_pkg::word_type      frame_words [mura_pkg::FRAME_DEPTH]
);

   logic               in_valid_ff, in_valid_in;
   mura_pkg::item_type item_ff;

   mura_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  rx_count_ff, rx_count_in;
   logic [23:0] rx_data_ff, rx_data_in;
   logic [7:0]  rx_sum_ff, rx_sum_in;
   logic [9:0]  wait_ff, wait_in;
   logic [4:0]  failures_ff, failures_in;
   logic        fault_ff, fault_in;

   logic [mura_pkg::CNT_W-1:0] step_cnt;
   logic        consume;
   logic        accept;
   logic        done_ok;
   logic [7:0]  addr_byte;
   logic [7:0]  wsum;
   logic [9:0]  wait_inc;
   logic [5:0]  fail_sum;
   logic        chk_ok;

   assign consume   = in_valid_ff && ((step_cnt == '0) || frame_free);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !consume);

   always_comb begin
      phase_in    = phase_ff;
      rx_count_in = rx_count_ff;
      rx_data_in  = rx_data_ff;
      rx_sum_in   = rx_sum_ff;
      wait_in     = wait_ff;
      failures_in = failures_ff;
      fault_in    = fault_ff;
      step_cnt    = '0;
      done_ok     = 1'b0;
      addr_byte   = {1'b0, item_ff.address};
      wsum        = '0;
      wait_inc    = wait_ff + 10'd1;
      fail_sum    = {1'b0, failures_ff} + 6'd1;
      chk_ok      = (~rx_sum_ff) == item_ff.rx_byte;
      for (int i = 0; i < mura_pkg::FRAME_DEPTH; i++) begin
         frame_words[i] = '0;
      end
      unique case (item_ff.req_type) inside
         mura_pkg::REQ_READ, mura_pkg::REQ_WRITE: begin
            if (phase_ff == mura_pkg::PH_IDLE) begin
               rx_count_in = '0;
               rx_data_in  = '0;
               wait_in     = '0;
               frame_words[0].tx_byte = cfg.head_byte;
               if (item_ff.req_type == mura_pkg::REQ_READ) begin
                  rx_sum_in = cfg.head_byte + addr_byte;
                  phase_in  = mura_pkg::PH_READ;
                  frame_words[1].tx_byte   = addr_byte;
                  frame_words[1].last_byte = 1'b1;
                  step_cnt = 3'd2;
               end else begin
                  addr_byte = {1'b1, item_ff.address};
                  wsum = cfg.head_byte + addr_byte + item_ff.write_data[15:8]
                       + item_ff.write_data[7:0];
                  rx_sum_in = '0;
                  phase_in  = mura_pkg::PH_WRITE;
                  frame_words[1].tx_byte   = addr_byte;
                  frame_words[2].tx_byte   = item_ff.write_data[15:8];
                  frame_words[3].tx_byte   = item_ff.write_data[7:0];
                  frame_words[4].tx_byte   = ~wsum;
                  frame_words[4].last_byte = 1'b1;
                  step_cnt = 3'd5;
               end
            end
         end
         mura_pkg::REQ_BYTE: begin
            if (phase_ff == mura_pkg::PH_WRITE) begin
               if (item_ff.rx_byte == mura_pkg::ACK_BYTE) begin
                  phase_in = mura_pkg::PH_IDLE;
                  done_ok  = 1'b1;
                  frame_words[0].result_kind = mura_pkg::KIND_WRITE;
                  frame_words[0].success     = 1'b1;
                  step_cnt = 3'd1;
               end
            end else if (phase_ff == mura_pkg::PH_READ) begin
               if (rx_count_ff != 2'd3) begin
                  rx_data_in  = {rx_data_ff[15:0], item_ff.rx_byte};
                  rx_sum_in   = rx_sum_ff + item_ff.rx_byte;
                  rx_count_in = rx_count_ff + 2'd1;
               end else begin
                  phase_in = mura_pkg::PH_IDLE;
                  done_ok  = 1'b1;
                  frame_words[0].result_kind = mura_pkg::KIND_READ;
                  frame_words[0].read_value  = chk_ok ? rx_data_ff : 24'd0;
                  frame_words[0].success     = chk_ok;
                  step_cnt = 3'd1;
               end
            end
         end
         mura_pkg::REQ_TICK: begin
            if (phase_ff != mura_pkg::PH_IDLE) begin
               if ((wait_inc >= cfg.timeout_ticks) || (wait_inc == '0)) begin
                  if (fail_sum >= {1'b0, cfg.fail_limit}) begin
                     failures_in = cfg.fail_limit;
                     fault_in    = 1'b1;
                  end else begin
                     failures_in = fail_sum[4:0];
                  end
                  frame_words[0].result_kind = (phase_ff == mura_pkg::PH_READ)
                                             ? mura_pkg::KIND_READ
                                             : mura_pkg::KIND_WRITE;
                  phase_in = mura_pkg::PH_IDLE;
                  wait_in  = '0;
                  step_cnt = 3'd1;
               end else begin
                  wait_in = wait_inc;
               end
            end
         end
         default: begin
            step_cnt = '0;
         end
      endcase
      if (done_ok) begin
         failures_in = '0;
         fault_in    = 1'b0;
         wait_in     = '0;
      end
      for (int i = 0; i < mura_pkg::FRAME_DEPTH; i++) begin
         frame_words[i].comm_fault = fault_in;
         frame_words[i].fail_count = failures_in;
      end
   end

   assign frame_ctl.load  = consume && (step_cnt != '0);
   assign frame_ctl.count = step_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= mura_pkg::PH_IDLE;
         rx_count_ff <= '0;
         rx_data_ff  <= '0;
         rx_sum_ff   <= '0;
         wait_ff     <= '0;
         failures_ff <= '0;
         fault_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (consume) begin
            phase_ff    <= phase_in;
            rx_count_ff <= rx_count_in;
            rx_data_ff  <= rx_data_in;
            rx_sum_ff   <= rx_sum_in;
            wait_ff     <= wait_in;
            failures_ff <= failures_in;
            fault_ff    <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   `MURA_ASSERT_NXT(a_read_starts, clock, reset,
      consume && phase_ff == mura_pkg::PH_IDLE && item_ff.req_type == mura_pkg::REQ_READ,
      phase_ff == mura_pkg::PH_READ)
   `MURA_ASSERT_NXT(a_ok_clears, clock, reset, consume && done_ok,
      failures_ff == '0 && !fault_ff)
   `MURA_ASSERT_IMP(a_idle_no_wait, clock, reset, phase_ff == mura_pkg::PH_IDLE,
      wait_ff == '0)

endmodule

`default_nettype wire

[design/mura_frame.sv]
// result frame buffer: holds up to five words and hands them out in order
// depends on mura_pkg and the shared assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "meter_uart_register_access_unit_defines.svh"

module mura_frame (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mura_pkg::frame_ctl_type frame_ctl,
   input  wire mura_pkg::word_type      frame_words [mura_pkg::FRAME_DEPTH],
   output logic                         frame_free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output mura_pkg::word_type           rsp_word
);

   mura_pkg::word_type word_ff [mura_pkg::FRAME_DEPTH];
   logic [mura_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [mura_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic take;
   logic last;

   assign rsp_valid  = idx_ff != cnt_ff;
   assign take       = rsp_valid && !rsp_stall;
   assign last       = (idx_ff + 3'd1) == cnt_ff;
   assign frame_free = !rsp_valid || (take && last);
   assign rsp_word   = rsp_valid ? word_ff[idx_ff] : '0;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (frame_ctl.load) begin
         cnt_in = frame_ctl.count;
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_ctl.load) begin
         for (int i = 0; i < mura_pkg::FRAME_DEPTH; i++) begin
            word_ff[i] <= frame_words[i];
         end
      end
   end

   `MURA_ASSERT_IMP(a_load_when_free, clock, reset, frame_ctl.load, frame_free)
   `MURA_ASSERT_IMP(a_idx_in_range, clock, reset, 1'b1,
      idx_ff <= cnt_ff && cnt_ff <= 3'd5)
   `MURA_ASSERT_NXT(a_load_shows, clock, reset, frame_ctl.load, rsp_valid && idx_ff == '0)

endmodule

`default_nettype wire

[design/meter_uart_register_access_unit.sv]
// an item is taken into the input register and stepped from there; its words are
// loaded into the five-entry frame buffer and offered from it, one per cycle unless the
// result port stalls. throughput: one item per cycle, but an item that loads words waits
// until the previous frame's last word is taken; a read loads two words, a write five.
// reset: synchronous, clears protocol state, failure count and fault flag and loads
// the register defaults (head 106, timeout 1000 ticks, failure limit 20).
// depends on mura_pkg, mura_core and mura_frame
`timescale 1ns / 1ps
`default_nettype none

module meter_uart_register_access_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [6:0]  req_address,
   input  wire logic [15:0] req_write_data,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_byte,
   output logic [23:0]      rsp_read_value,
   output logic             rsp_success,
   output logic             rsp_comm_fault,
   output logic [4:0]       rsp_fail_count
);

   mura_pkg::cfg_type       cfg_ff;
   mura_pkg::item_type      req_item;
   mura_pkg::frame_ctl_type frame_ctl;
   mura_pkg::word_type      frame_words [mura_pkg::FRAME_DEPTH];
   mura_pkg::word_type      rsp_word;
   logic                    frame_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte     <= mura_pkg::HEAD_RESET;
         cfg_ff.timeout_ticks <= mura_pkg::TIMEOUT_RESET;
         cfg_ff.fail_limit    <= mura_pkg::LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mura_pkg::CSR_HEAD:    cfg_ff.head_byte     <= csr_wdata[7:0];
            mura_pkg::CSR_TIMEOUT: cfg_ff.timeout_ticks <= csr_wdata;
            mura_pkg::CSR_LIMIT:   cfg_ff.fail_limit    <= csr_wdata[4:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign req_item.req_type   = req_type;
   assign req_item.address    = req_address;
   assign req_item.write_data = req_write_data;
   assign req_item.rx_byte    = req_rx_byte;

   mura_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .cfg         (cfg_ff),
      .frame_free  (frame_free),
      .frame_ctl   (frame_ctl),
      .frame_words (frame_words)
   );

   mura_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .frame_ctl   (frame_ctl),
      .frame_words (frame_words),
      .frame_free  (frame_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   assign rsp_result_kind = rsp_word.result_kind;
   assign rsp_tx_byte     = rsp_word.tx_byte;
   assign rsp_last_byte   = rsp_word.last_byte;
   assign rsp_read_value  = rsp_word.read_value;
   assign rsp_success     = rsp_word.success;
   assign rsp_comm_fault  = rsp_word.comm_fault;
   assign rsp_fail_count  = rsp_word.fail_count;

endmodule

`default_nettype wire

[sim/mura_check_pkg.sv]
// scoreboard for the meter uart register access unit: tracks protocol state and
// the expected result words, and compares the words the block returns
// depends on mura_pkg
`timescale 1ns / 1ps

package mura_check_pkg;
   import mura_pkg::*;

   class reg_access_tracker;
      logic [7:0]  head;
      logic [9:0]  tick_limit;
      logic [4:0]  fail_limit;
      phase_type   phase;
      int unsigned rx_seen;
      logic [23:0] rx_data;
      logic [7:0]  rx_sum;
      logic [9:0]  ticks;
      logic [4:0]  failures;
      logic        fault;
      word_type    expected_words[$];
      int mismatches;
      int words_checked;
      int reads_good;
      int reads_bad;
      int writes_acked;
      int timeouts;
      int faulted_timeouts;

      function new();
         head = HEAD_RESET;
         tick_limit = TIMEOUT_RESET;
         fail_limit = LIMIT_RESET;
         phase = PH_IDLE;
         rx_seen = 0;
         rx_data = '0;
         rx_sum = '0;
         ticks = '0;
         failures = '0;
         fault = 1'b0;
         mismatches = 0;
         words_checked = 0;
         reads_good = 0;
         reads_bad = 0;
         writes_acked = 0;
         timeouts = 0;
         faulted_timeouts = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [9:0] value);
         case (index)
            CSR_HEAD:    head = value[7:0];
            CSR_TIMEOUT: tick_limit = value;
            CSR_LIMIT:   fail_limit = value[4:0];
            default: ;
         endcase
      endfunction

      function void push_word(logic [1:0] kind, logic [7:0] tx, logic last,
                              logic [23:0] value, logic ok);
         word_type w;
         w.result_kind = kind;
         w.tx_byte = tx;
         w.last_byte = last;
         w.read_value = value;
         w.success = ok;
         w.comm_fault = fault;
         w.fail_count = failures;
         expected_words.push_back(w);
      endfunction

      // one accepted input word
      function void note_request(item_type it);
         logic [7:0] frame_sum;
         logic [5:0] next_fails;
         logic [1:0] kind;
         logic       ok;
         case (it.req_type)
            REQ_READ, REQ_WRITE: begin
               if (phase != PH_IDLE) return;
               rx_seen = 0;
               rx_data = '0;
               ticks = '0;
               if (it.req_type == REQ_READ) begin
                  rx_sum = head + {1'b0, it.address};
                  phase = PH_READ;
                  push_word(KIND_TX, head, 1'b0, 24'd0, 1'b0);
                  push_word(KIND_TX, {1'b0, it.address}, 1'b1, 24'd0, 1'b0);
               end else begin
                  frame_sum = head + {1'b1, it.address} + it.write_data[15:8]
                              + it.write_data[7:0];
                  rx_sum = '0;
                  phase = PH_WRITE;
                  push_word(KIND_TX, head, 1'b0, 24'd0, 1'b0);
                  push_word(KIND_TX, {1'b1, it.address}, 1'b0, 24'd0, 1'b0);
                  push_word(KIND_TX, it.write_data[15:8], 1'b0, 24'd0, 1'b0);
                  push_word(KIND_TX, it.write_data[7:0], 1'b0, 24'd0, 1'b0);
                  push_word(KIND_TX, ~frame_sum, 1'b1, 24'd0, 1'b0);
               end
            end
            REQ_BYTE: begin
               if (phase == PH_WRITE) begin
                  if (it.rx_byte == ACK_BYTE) begin
                     phase = PH_IDLE;
                     failures = '0;
                     fault = 1'b0;
                     writes_acked++;
                     push_word(KIND_WRITE, 8'd0, 1'b0, 24'd0, 1'b1);
                  end
               end else if (phase == PH_READ) begin
                  if (rx_seen < 3) begin
                     rx_data = {rx_data[15:0], it.rx_byte};
                     rx_sum = rx_sum + it.rx_byte;
                     rx_seen++;
                  end else begin
                     ok = ((~rx_sum) == it.rx_byte);
                     phase = PH_IDLE;
                     failures = '0;
                     fault = 1'b0;
                     if (ok) reads_good++;
                     else reads_bad++;
                     push_word(KIND_READ, 8'd0, 1'b0, ok ? rx_data : 24'd0, ok);
                  end
               end
            end
            default: begin
               if (phase != PH_IDLE) begin
                  ticks = ticks + 10'd1;
                  if (ticks >= tick_limit || ticks == 10'd0) begin
                     kind = (phase == PH_READ) ? KIND_READ : KIND_WRITE;
                     next_fails = failures + 6'd1;
                     if (next_fails >= {1'b0, fail_limit}) begin
                        next_fails = {1'b0, fail_limit};
                        fault = 1'b1;
                     end
                     failures = next_fails[4:0];
                     phase = PH_IDLE;
                     ticks = '0;
                     timeouts++;
                     if (fault) faulted_timeouts++;
                     push_word(kind, 8'd0, 1'b0, 24'd0, 1'b0);
                  end
               end
            end
         endcase
      endfunction

      task report(string what, logic [23:0] got, logic [23:0] want);
         mismatches++;
         if (mismatches <= 40) $display("mismatch %s: got %0h, expected %0h", what, got, want);
      endtask

      task check_word(word_type got);
         word_type want;
         if (expected_words.size() == 0) begin
            report("word with nothing pending, kind", got.result_kind, 24'd0);
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.result_kind !== want.result_kind)
            report("result_kind", got.result_kind, want.result_kind);
         if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
         if (got.last_byte !== want.last_byte)
            report("last_byte", got.last_byte, want.last_byte);
         if (got.read_value !== want.read_value)
            report("read_value", got.read_value, want.read_value);
         if (got.success !== want.success) report("success", got.success, want.success);
         if (got.comm_fault !== want.comm_fault)
            report("comm_fault", got.comm_fault, want.comm_fault);
         if (got.fail_count !== want.fail_count)
            report("fail_count", got.fail_count, want.fail_count);
      endtask
   endclass

endpackage

[sim/tb_top.sv]
// top of the register access unit testbench: clock, reset, drivers for the request,
// result and register ports, directed and random frames, end of run
// depends on mura_pkg, mura_check_pkg and meter_uart_register_access_unit
`timescale 1ns / 1ps

module tb_top;
   import mura_pkg::*;
   import mura_check_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = CSR_HEAD;
   logic [9:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_TICK;
   logic [6:0]  req_address = '0;
   logic [15:0] req_write_data = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;
   logic [23:0] rsp_read_value;
   logic        rsp_success;
   logic        rsp_comm_fault;
   logic [4:0]  rsp_fail_count;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   items_sent = 0;
   logic hold_active = 1'b0;
   event holdoff_go;

   reg_access_tracker tracker = new();

   meter_uart_register_access_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_read_value  (rsp_read_value),
      .rsp_success     (rsp_success),
      .rsp_comm_fault  (rsp_comm_fault),
      .rsp_fail_count  (rsp_fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word(word_type'{rsp_result_kind, rsp_tx_byte, rsp_last_byte,
                                       rsp_read_value, rsp_success, rsp_comm_fault,
                                       rsp_fail_count});
   end

   always @(posedge clock) begin
      rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);
   end

   // long result hold-off
   always begin
      @(holdoff_go);
      hold_active <= 1'b1;
      repeat (400) @(posedge clock);
      hold_active <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("timeout after %0d input words", items_sent);
      $display("FAIL meter_uart_register_access_unit");
      $finish;
   end

   task automatic offer(logic [1:0] kind, logic [6:0] addr, logic [15:0] data,
                        logic [7:0] rxb);
      item_type it;
      it = item_type'{kind, addr, data, rxb};
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_address <= addr;
      req_write_data <= data;
      req_rx_byte <= rxb;
      do @(posedge clock); while (req_stall);
      tracker.note_request(it);
      items_sent++;
   endtask

   task automatic send_read(logic [6:0] addr);
      offer(REQ_READ, addr, 16'($urandom_range(65535)), 8'($urandom_range(255)));
   endtask

   task automatic send_write(logic [6:0] addr, logic [15:0] data);
      offer(REQ_WRITE, addr, data, 8'($urandom_range(255)));
   endtask

   task automatic send_byte(logic [7:0] rxb);
      offer(REQ_BYTE, 7'($urandom_range(127)), 16'($urandom_range(65535)), rxb);
   endtask

   task automatic send_tick();
      offer(REQ_TICK, 7'($urandom_range(127)), 16'($urandom_range(65535)),
            8'($urandom_range(255)));
   endtask

   task automatic write_regs(logic [7:0] head, logic [9:0] tmo, logic [4:0] limit);
      csr_write_en <= 1'b1;
      csr_index <= CSR_HEAD;
      csr_wdata <= {2'b00, head};
      @(posedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= {5'd0, limit};
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.write_reg(CSR_HEAD, {2'b00, head});
      tracker.write_reg(CSR_TIMEOUT, tmo);
      tracker.write_reg(CSR_LIMIT, {5'd0, limit});
   endtask

   // close any open frame, then let every pending word come out
   task automatic settle();
      while (tracker.phase == PH_WRITE) send_byte(ACK_BYTE);
      while (tracker.phase == PH_READ) send_byte(8'($urandom_range(255)));
      req_valid <= 1'b0;
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_transaction();
      logic [7:0] sum;
      logic [7:0] b;
      logic [6:0] addr;
      int         pick;
      pick = $urandom_range(99);
      addr = 7'($urandom_range(127));
      if (pick < 12) begin
         offer(2'($urandom_range(3)), addr, 16'($urandom_range(65535)),
               8'($urandom_range(255)));
      end else if (pick < 56) begin
         send_read(addr);
         sum = tracker.head + {1'b0, addr};
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(99) < 15) send_tick();
            b = 8'($urandom_range(255));
            sum = sum + b;
            send_byte(b);
         end
         if ($urandom_range(99) < 15) send_tick();
         if ($urandom_range(99) < 75) send_byte(~sum);
         else send_byte(8'($urandom_range(255)));
      end else begin
         send_write(addr, 16'($urandom_range(65535)));
         for (int k = 0; k < 12 && tracker.phase == PH_WRITE; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) send_byte(ACK_BYTE);
            else if (pick < 70) send_tick();
            else send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic run_random(int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) random_transaction();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset register values: ignored words, good read, write with noise, bad checksum
      send_tick();
      send_byte(ACK_BYTE);
      send_read(7'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(~(HEAD_RESET + 8'hFF + 8'hFF + 8'hFF));
      send_write(7'h7F, 16'hFFFF);
      send_read(7'h15);
      send_byte(8'hAB);
      send_tick();
      send_byte(ACK_BYTE);
      send_read(7'h7F);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      settle();

      // timeouts up to the failure limit, then an ack clears the fault
      write_regs(8'hFF, 10'd2, 5'd2);
      send_read(7'h2A);
      send_tick();
      send_tick();
      send_write(7'h55, 16'h0000);
      send_tick();
      send_tick();
      send_write(7'h33, 16'h1234);
      send_byte(ACK_BYTE);
      settle();

      // zero timeout and zero limit
      write_regs(8'h00, 10'd0, 5'd0);
      send_read(7'h10);
      send_tick();
      send_write(7'h6B, 16'h5AA5);
      send_tick();
      settle();

      write_regs(8'($urandom_range(255)), 10'd2, 5'd2);
      send_idle_pct = 0;
      stall_pct = 0;
      run_random(50);
      settle();

      write_regs(8'h55, 10'd1023, 5'd31);
      send_idle_pct = 75;
      stall_pct = 0;
      run_random(50);
      settle();

      write_regs(8'($urandom_range(255)), 10'd3, 5'd3);
      send_idle_pct = 0;
      stall_pct = 75;
      run_random(50);
      settle();

      write_regs(HEAD_RESET, 10'd1, 5'd1);
      send_idle_pct = 19;
      stall_pct = 19;
      run_random(50);
      settle();

      // result port held off while requests keep coming
      write_regs(8'hAA, 10'd5, 5'd31);
      send_idle_pct = 0;
      stall_pct = 0;
      -> holdoff_go;
      run_random(60);
      settle();

      if (tracker.expected_words.size() != 0)
         tracker.report("words never returned", tracker.expected_words.size(), 24'd0);
      $display("covered %0d input words and %0d result words over eight register settings",
               items_sent, tracker.words_checked);
      $display("reads good %0d, bad checksum %0d, writes acked %0d, timeouts %0d (%0d faulted)",
               tracker.reads_good, tracker.reads_bad, tracker.writes_acked,
               tracker.timeouts, tracker.faulted_timeouts);
      if (tracker.mismatches == 0) begin
         $display("PASS meter_uart_register_access_unit");
      end else begin
         $display("FAIL meter_uart_register_access_unit");
      end
      $finish;
   end

endmodule
